[design/sssd_pkg.sv]
// ----------------------------------------------------------------------------
// sssd_pkg: shared types, constants and lookup functions
// Segment codes, select codes, register indexes and the character map for
// the four-digit multiplexed seven-segment scan driver.
// ----------------------------------------------------------------------------
package sssd_pkg;

   // Geometry
   localparam int unsigned DIGITS        = 4;
   localparam int unsigned DIGIT_IDX_W   = 2;
   localparam int unsigned COUNT_W       = 3;
   localparam int unsigned SEG_W         = 8;
   localparam int unsigned PRESCALE_W    = 8;
   localparam int unsigned BRIGHT_W      = 4;
   localparam int unsigned CSR_IDX_W     = 2;
   localparam int unsigned CSR_DATA_W    = 4;

   // Default prescaler reload (range 2..255)
   localparam int unsigned SCALER_RELOAD_DEF = 16;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DISPLAY_ENABLED = 2'd0,
      CSR_INVERT_SEGMENTS = 2'd1,
      CSR_RIGHT_TO_LEFT   = 2'd2,
      CSR_BRIGHTNESS      = 2'd3
   } csr_idx_type;

   // Input item kinds
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_CHAR = 1'b1;

   // Character codes with special meaning
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_DOT = 8'h2E;

   // Segment patterns (active low, bit 7 is the decimal point)
   localparam logic [SEG_W-1:0] SEG_BLANK   = 8'd255;
   localparam logic [SEG_W-1:0] SEG_DASH    = 8'd191;
   localparam logic [SEG_W-1:0] SEG_UNDER   = 8'd247;
   localparam logic [SEG_W-1:0] SEG_DOT     = 8'd127;
   localparam logic [SEG_W-1:0] SEG_UNKNOWN = 8'd182;
   localparam logic [SEG_W-1:0] SEG_DP_MASK = 8'h7F;

   // Digit select codes
   localparam logic [SEG_W-1:0] SEL_D0 = 8'hF1;
   localparam logic [SEG_W-1:0] SEL_D1 = 8'hF2;
   localparam logic [SEG_W-1:0] SEL_D2 = 8'hF4;
   localparam logic [SEG_W-1:0] SEL_D3 = 8'hF8;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic                display_enabled;
      logic                invert_segments;
      logic                right_to_left;
      logic [BRIGHT_W-1:0] brightness;
   } csr_type;

   // One scan frame leaving the scan stage
   typedef struct packed {
      logic             valid;
      logic [SEG_W-1:0] segment_byte;
      logic [SEG_W-1:0] select_byte;
   } frame_type;

   typedef logic [DIGITS-1:0][SEG_W-1:0] digit_array_type;

   // Digits '0'..'9'
   function automatic logic [SEG_W-1:0] digit_segments(input logic [3:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h82;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h90;
         default: s = SEG_UNKNOWN;
      endcase
      return s;
   endfunction

   // Letters, offset from 'a'
   function automatic logic [SEG_W-1:0] letter_segments(input logic [4:0] l);
      logic [SEG_W-1:0] s;
      case (l)
         5'd0:    s = 8'd136;
         5'd1:    s = 8'd131;
         5'd2:    s = 8'd167;
         5'd3:    s = 8'd161;
         5'd4:    s = 8'd134;
         5'd5:    s = 8'd142;
         5'd6:    s = 8'd144;
         5'd7:    s = 8'd139;
         5'd8:    s = 8'd207;
         5'd9:    s = 8'd241;
         5'd11:   s = 8'd199;
         5'd13:   s = 8'd171;
         5'd14:   s = 8'd163;
         5'd15:   s = 8'd140;
         5'd16:   s = 8'd152;
         5'd17:   s = 8'd175;
         5'd18:   s = 8'd146;
         5'd19:   s = 8'd135;
         5'd20:   s = 8'd227;
         5'd24:   s = 8'd145;
         default: s = SEG_UNKNOWN;
      endcase
      return s;
   endfunction

   // Full character map; letters are case-folded
   function automatic logic [SEG_W-1:0] char_segments(input logic [7:0] c);
      logic [7:0]       folded;
      logic [7:0]       digit_off;
      logic [7:0]       letter_off;
      logic [SEG_W-1:0] s;
      folded     = c | 8'h20;
      digit_off  = c - 8'h30;
      letter_off = folded - 8'h61;
      if (c inside {[8'h30:8'h39]}) begin
         s = digit_segments(digit_off[3:0]);
      end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
         s = letter_segments(letter_off[4:0]);
      end else begin
         case (c)
            8'h2D:    s = SEG_DASH;
            CHAR_DOT: s = SEG_DOT;
            8'h5F:    s = SEG_UNDER;
            8'h20:    s = SEG_BLANK;
            default:  s = SEG_UNKNOWN;
         endcase
      end
      return s;
   endfunction

   // Digit select code for a scan position
   function automatic logic [SEG_W-1:0] select_code(input logic [DIGIT_IDX_W-1:0] idx,
                                                    input logic rtl);
      logic [DIGIT_IDX_W-1:0] pos;
      logic [SEG_W-1:0]       s;
      pos = rtl ? ~idx : idx;
      case (pos)
         2'd0:    s = SEL_D0;
         2'd1:    s = SEL_D1;
         2'd2:    s = SEL_D2;
         2'd3:    s = SEL_D3;
         default: s = SEL_D0;
      endcase
      return s;
   endfunction

endpackage

[design/seven_segment_scan_driver_unit.sv]
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_unit: four-digit multiplexed 7-segment driver
// Text items fill display memory; tick items scan it and produce frames of
// segment byte and digit select byte.
//
//   channel  dir  handshake          payload
//   req_     in   req_valid/stall    req_mode, req_char_code
//   rsp_     out  rsp_valid/stall    rsp_segment_byte, rsp_select_byte
//   csr_     in   csr_write_enable   csr_index, csr_write_data
//
// An item is registered on accept and processed once the result register can
// take its frame; one item per cycle sustained while no frame is held stalled.
// A frame passes through the input register and the result register to the rsp_ ports.
// rsp_stall holds the result register and, once the input register is full,
// raises req_stall in the same cycle.
// Synchronous reset empties both registers, blanks display memory and reloads
// the prescaler.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_unit
   import sssd_pkg::*;
#(
   parameter int unsigned SCALER_RELOAD = SCALER_RELOAD_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [7:0]            req_char_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SEG_W-1:0]      rsp_segment_byte,
   output logic [SEG_W-1:0]      rsp_select_byte,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam logic [PRESCALE_W-1:0] RELOAD_VAL = PRESCALE_W'(SCALER_RELOAD);
   localparam logic [BRIGHT_W-1:0]   BRIGHT_MAX = BRIGHT_W'(SCALER_RELOAD - 1);

   csr_type csr_ff, csr_in;

   logic       in_valid_ff, in_valid_in;
   logic       in_mode_ff;
   logic [7:0] in_char_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [SEG_W-1:0] rsp_seg_ff;
   logic [SEG_W-1:0] rsp_sel_ff;

   logic            req_accept;
   logic            advance;
   logic            fire;
   digit_array_type display_memory;
   frame_type       frame;

   // Configuration writes, brightness clamped below the reload value
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_DISPLAY_ENABLED: csr_in.display_enabled = csr_write_data[0];
            CSR_INVERT_SEGMENTS: csr_in.invert_segments = csr_write_data[0];
            CSR_RIGHT_TO_LEFT:   csr_in.right_to_left   = csr_write_data[0];
            CSR_BRIGHTNESS: begin
               if (PRESCALE_W'(csr_write_data) >= RELOAD_VAL) begin
                  csr_in.brightness = BRIGHT_MAX;
               end else begin
                  csr_in.brightness = csr_write_data;
               end
            end
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Handshake: the held item moves on when the result slot is free
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign fire        = in_valid_ff && advance;
   assign req_stall   = in_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the item payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_mode_ff <= req_mode;
         in_char_ff <= req_char_code;
      end
   end

   sssd_text u_text (
      .clock          (clock),
      .reset          (reset),
      .char_valid     (fire && in_mode_ff == MODE_CHAR),
      .char_code      (in_char_ff),
      .display_memory (display_memory)
   );

   sssd_scan #(
      .SCALER_RELOAD (SCALER_RELOAD)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .tick_valid     (fire && in_mode_ff == MODE_TICK),
      .csr            (csr_ff),
      .display_memory (display_memory),
      .frame          (frame)
   );

   // Result register: load on fire, hold while stalled, drop when taken
   always_comb begin
      if (fire) begin
         rsp_valid_in = frame.valid;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && frame.valid) begin
         rsp_seg_ff <= frame.segment_byte;
         rsp_sel_ff <= frame.select_byte;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_segment_byte = rsp_seg_ff;
   assign rsp_select_byte  = rsp_sel_ff;

endmodule

[design/sssd_text.sv]
// ----------------------------------------------------------------------------
// sssd_text: text staging and display memory
// Maps characters to segment bytes into a four-position staging buffer,
// merges decimal points and copies the buffer to display memory on NUL.
// ----------------------------------------------------------------------------
module sssd_text
   import sssd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            char_valid,
   input  logic [7:0]      char_code,
   output digit_array_type display_memory
);

   digit_array_type    staging_ff, staging_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   digit_array_type    display_ff, display_in;

   logic [DIGIT_IDX_W-1:0] last_idx;
   logic [COUNT_W-1:0]     count_dec;

   assign count_dec = count_ff - COUNT_W'(1);
   assign last_idx  = count_dec[DIGIT_IDX_W-1:0];

   // Stage, merge or commit one character
   always_comb begin
      staging_in = staging_ff;
      count_in   = count_ff;
      display_in = display_ff;
      if (char_valid) begin
         if (char_code == CHAR_NUL) begin
            for (int i = 0; i < DIGITS; i++) begin
               display_in[i] = (COUNT_W'(i) >= count_ff) ? SEG_BLANK : staging_ff[i];
            end
            count_in = '0;
         end else if (count_ff < COUNT_W'(DIGITS)) begin
            if (char_code == CHAR_DOT && count_ff != '0) begin
               staging_in[last_idx] = staging_ff[last_idx] & SEG_DP_MASK;
            end else begin
               staging_in[count_ff[DIGIT_IDX_W-1:0]] = char_segments(char_code);
               count_in = count_ff + COUNT_W'(1);
            end
         end
      end
   end

   // Staging buffer carries no reset
   always_ff @(posedge clock) begin
      staging_ff <= staging_in;
   end

   // Count and display memory
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         display_ff <= {DIGITS{SEG_BLANK}};
      end else begin
         count_ff   <= count_in;
         display_ff <= display_in;
      end
   end

   assign display_memory = display_ff;

endmodule

[design/sssd_scan.sv]
// ----------------------------------------------------------------------------
// sssd_scan: prescaler and digit scan
// Counts scan ticks down, emits the current digit at reload and blanks the
// previous digit when the count reaches the brightness level.
// ----------------------------------------------------------------------------
module sssd_scan
   import sssd_pkg::*;
#(
   parameter int unsigned SCALER_RELOAD = SCALER_RELOAD_DEF
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            tick_valid,
   input  csr_type         csr,
   input  digit_array_type display_memory,
   output frame_type       frame
);

   localparam logic [PRESCALE_W-1:0] RELOAD_VAL = PRESCALE_W'(SCALER_RELOAD);

   logic [PRESCALE_W-1:0]  prescaler_ff, prescaler_in;
   logic [DIGIT_IDX_W-1:0] index_ff, index_in;

   logic [PRESCALE_W-1:0]  count_dec;
   logic [DIGIT_IDX_W-1:0] frame_idx;
   logic [SEG_W-1:0]       frame_seg;
   logic                   frame_valid;

   assign count_dec = prescaler_ff - PRESCALE_W'(1);

   // Advance the prescaler and pick the frame, if any
   always_comb begin
      prescaler_in = prescaler_ff;
      index_in     = index_ff;
      frame_idx    = index_ff;
      frame_seg    = SEG_BLANK;
      frame_valid  = 1'b0;
      if (tick_valid) begin
         if (count_dec == '0) begin
            prescaler_in = RELOAD_VAL;
            index_in     = index_ff + DIGIT_IDX_W'(1);
            frame_seg    = display_memory[index_ff];
            frame_valid  = csr.display_enabled;
         end else begin
            prescaler_in = count_dec;
            frame_idx    = index_ff - DIGIT_IDX_W'(1);
            frame_valid  = csr.display_enabled &&
                           (count_dec == PRESCALE_W'(csr.brightness));
         end
      end
   end

   assign frame.valid        = frame_valid;
   assign frame.segment_byte = frame_seg ^ {SEG_W{csr.invert_segments}};
   assign frame.select_byte  = select_code(frame_idx, csr.right_to_left);

   // Hold scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         prescaler_ff <= RELOAD_VAL;
         index_ff     <= '0;
      end else begin
         prescaler_ff <= prescaler_in;
         index_ff     <= index_in;
      end
   end

endmodule

[design/sssd_checker.sv]
// ----------------------------------------------------------------------------
// sssd_checker: port-level checks for the scan driver
// Watches reset, the result handshake and the select codes on the top level.
// ----------------------------------------------------------------------------
module sssd_checker
   import sssd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [SEG_W-1:0] rsp_segment_byte,
   input logic [SEG_W-1:0] rsp_select_byte
);

   // Reset leaves no frame pending
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("frame pending right after reset");

   // A frame always selects exactly one digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_select_byte == SEL_D0 || rsp_select_byte == SEL_D1 ||
                     rsp_select_byte == SEL_D2 || rsp_select_byte == SEL_D3))
      else $error("illegal digit select code");

   // Input backpressure only comes from a held frame
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled frame");

   // A stalled frame holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_segment_byte) &&
                                 $stable(rsp_select_byte))
      else $error("stalled frame changed");

endmodule

bind seven_segment_scan_driver_unit sssd_checker u_sssd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_segment_byte (rsp_segment_byte),
   .rsp_select_byte  (rsp_select_byte)
);
